/* src/cli_pkg.sv */
// Package for the cubic interpolation line search block.
// Holds default widths, register reset values, codes and shared types.
package cli_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CFG_W          = 31;
  localparam int CFG_ADDR_W     = 2;
  localparam int ITER_W         = 8;

  localparam logic [CFG_W-1:0]  TOL_RST   = 31'd66;
  localparam logic [CFG_W-1:0]  STEP_RST  = 31'd655360;
  localparam logic [ITER_W-1:0] MAXIT_RST = 8'd100;

  localparam logic [CFG_ADDR_W-1:0] CFG_TOL   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAXIT = 2'd2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  typedef enum logic [1:0] {
    KIND_EVAL = 2'd0,
    KIND_CONV = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIT,
    PH_FINAL
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADV,
    ST_FIN,
    ST_FAIL,
    ST_DIV1,
    ST_D1,
    ST_SQA,
    ST_SQB,
    ST_SQC,
    ST_SQRT,
    ST_DEN,
    ST_DIV2,
    ST_STEP,
    ST_UPD
  } state_t;

  // status of a multi-cycle arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

/* src/cli_div.sv */
// Restoring fixed-point divider: (num * 2^F) / den, truncated, saturated.
// One quotient bit per cycle. Depends on cli_pkg.
module cli_div import cli_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [W+2:0]   num,
  input  logic signed [W+2:0]   den,
  output logic signed [W-1:0]   quo,
  output unit_stat_t            stat
);

  localparam int NW   = W + 3;
  localparam int DW   = NW + F;
  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   dvd_r;
  logic [NW-1:0]   rem_r;
  logic [NW-1:0]   ud_r;
  logic [W-1:0]    q_r;
  logic            ovf_r;
  logic            neg_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [NW-1:0]   un;
  logic [NW-1:0]   ud;
  logic [NW:0]     shifted;
  logic [NW:0]     trial;

  assign un      = num[NW-1] ? NW'(-num) : NW'(num);
  assign ud      = den[NW-1] ? NW'(-den) : NW'(den);
  assign shifted = {rem_r, dvd_r[DW-1]};
  assign trial   = shifted - {1'b0, ud_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {un, {F{1'b0}}};
      rem_r <= '0;
      ud_r  <= ud;
      q_r   <= '0;
      ovf_r <= 1'b0;
      neg_r <= num[NW-1] ^ den[NW-1];
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      rem_r <= trial[NW] ? shifted[NW-1:0] : trial[NW-1:0];
      q_r   <= {q_r[W-2:0], ~trial[NW]};
      ovf_r <= ovf_r | q_r[W-1];
    end
  end

  always_comb begin
    if (neg_r) begin
      if (ovf_r || (q_r[W-1] && |q_r[W-2:0])) quo = {1'b1, {(W-1){1'b0}}};
      else                                      quo = -$signed(q_r);
    end else begin
      if (ovf_r || q_r[W-1]) quo = {1'b0, {(W-1){1'b1}}};
      else                   quo = $signed(q_r);
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* src/cli_sqrt.sv */
// Bit-serial integer square root (floor), two radicand bits per cycle.
// Depends on cli_pkg.
module cli_sqrt import cli_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [2*W-1:0] rad,
  output logic [W-1:0]   root,
  output unit_stat_t     stat
);

  localparam int CNTW = $clog2(W + 1);

  logic [2*W-1:0]  v_r;
  logic [W:0]      rem_r;
  logic [W-1:0]    root_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [W+2:0]    shifted;
  logic [W+2:0]    trial;

  assign shifted = {rem_r, v_r[2*W-1:2*W-2]};
  assign trial   = shifted - {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r    <= {v_r[2*W-3:0], 2'b00};
      rem_r  <= trial[W+2] ? shifted[W:0] : trial[W:0];
      root_r <= {root_r[W-2:0], ~trial[W+2]};
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* src/cubic_interp_line_search_top.sv */
// Top level of the cubic interpolation line search.
// Depends on cli_pkg, cli_div and cli_sqrt.
//
// channel   dir  beat contents
// in_*      in   tuser: op; tdata: position, value, slope
// out_*     out  tuser: kind; tdata: result_position, result_value, iterations
// cfg_*     in   register index and write data, no read-back
//
// A start beat passes to the advance state, where its result is loaded once the output
// is free; in_tready rises again after that. A fit runs two passes of the shared
// one-bit-per-cycle divider, one pass of the square-root unit and the steps D1, SQA,
// SQB, SQC, DEN, STEP and UPD.
// in_tready is high only while the sequencer is idle. A waiting result holds
// the sequencer in its emit state. Reset is synchronous, active low.
module cubic_interp_line_search_top import cli_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // position, value, slope
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]          in_tdata,
  // op
  input  logic [0:0]                                 in_tuser,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // result_position, result_value, iterations
  output logic [((2*DATA_WIDTH+ITER_W+7)/8)*8-1:0]   out_tdata,
  // kind
  output logic [1:0]                                 out_tuser,
  input  logic                                       cfg_we,
  input  logic [CFG_ADDR_W-1:0]                      cfg_addr,
  input  logic [CFG_W-1:0]                           cfg_wdata
);

  localparam int W       = DATA_WIDTH;
  localparam int F       = FRAC_BITS;
  localparam int NW      = W + 3;
  localparam int PW      = 2*W + 2;
  localparam int SATW    = 2*W + 4;
  localparam int AW      = ((W > CFG_W) ? W : CFG_W) + 2;
  localparam int OUT_TDW = ((2*W+ITER_W+7)/8)*8;

  localparam logic signed [SATW-1:0] QMAX_X = {{(SATW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SATW-1:0] QMIN_X = ~QMAX_X;

  function automatic logic signed [W-1:0] sat(input logic signed [SATW-1:0] v);
    logic signed [W-1:0] r;
    if (v > QMAX_X)      r = QMAX_X[W-1:0];
    else if (v < QMIN_X) r = QMIN_X[W-1:0];
    else                 r = v[W-1:0];
    return r;
  endfunction

  // configuration
  logic [CFG_W-1:0]  tol_r;
  logic [CFG_W-1:0]  step_r;
  logic [ITER_W-1:0] maxit_r;

  // search state
  state_t              st_r, st_nxt;
  phase_t              phase_r;
  logic signed [W-1:0] kept_pos_r, kept_val_r, kept_slp_r, probe_r;
  logic signed [W-1:0] ev_val_r, ev_slp_r, d1_r;
  logic [ITER_W-1:0]   fit_r;
  logic signed [PW-1:0] prod_r, sq_r;

  // result register
  logic                out_tvalid_r;
  kind_t               out_kind_r;
  logic signed [W-1:0] out_pos_r, out_val_r;
  logic [ITER_W-1:0]   out_iter_r;

  logic                in_op;
  logic signed [W-1:0] in_pos, in_val, in_slp;
  logic                acc, out_free, out_load;

  logic signed [NW-1:0] f_diff, div1_num, div1_den, div2_num, div2_den;
  logic signed [NW-1:0] div_num, div_den;
  logic                 div_start, sq_start;
  logic signed [W-1:0]  quo;
  unit_stat_t           div_stat, sq_stat;
  logic [W-1:0]         root;
  logic signed [W-1:0]  s_clip, d2;
  logic signed [PW:0]   disc;

  logic signed [W:0]    mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW:0]   rnd, pr_adj, stepq;
  logic signed [W-1:0]  xn, start_probe;
  logic signed [W:0]    xdiff;
  logic signed [W+1:0]  dd;
  logic [W+1:0]         dist_u;
  logic                 far;

  assign in_op  = in_tuser[0];
  assign in_pos = in_tdata[W-1:0];
  assign in_val = in_tdata[2*W-1:W];
  assign in_slp = in_tdata[3*W-1:2*W];

  assign in_tready = (st_r == ST_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign out_load  = (st_r == ST_ADV || st_r == ST_FIN || st_r == ST_FAIL) && out_free;

  // fit arithmetic
  assign f_diff   = NW'(kept_val_r) - NW'(in_val);
  assign div1_num = (f_diff <<< 1) + f_diff;
  assign div1_den = NW'(kept_pos_r) - NW'(probe_r);
  assign s_clip   = root[W-1] ? QMAX_X[W-1:0] : $signed(root);
  assign d2       = (probe_r > kept_pos_r) ? s_clip : -s_clip;
  assign div2_num = NW'(ev_slp_r) + NW'(d2) - NW'(d1_r);
  assign div2_den = NW'(ev_slp_r) - NW'(kept_slp_r) + (NW'(d2) <<< 1);
  assign div_num  = (st_r == ST_IDLE) ? div1_num : div2_num;
  assign div_den  = (st_r == ST_IDLE) ? div1_den : div2_den;
  assign disc     = (PW+1)'(sq_r) - (PW+1)'(prod_r);
  assign xdiff    = (W+1)'(probe_r) - (W+1)'(kept_pos_r);

  always_comb begin
    case (st_r)
      ST_SQB: begin
        mul_a = (W+1)'(kept_slp_r);
        mul_b = (W+1)'(ev_slp_r);
      end
      ST_STEP: begin
        mul_a = xdiff;
        mul_b = (W+1)'(quo);
      end
      default: begin
        mul_a = (W+1)'(d1_r);
        mul_b = (W+1)'(d1_r);
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign rnd    = prod_r[PW-1] ? (PW+1)'((1 << F) - 1) : '0;
  assign pr_adj = (PW+1)'(prod_r) + rnd;
  assign stepq  = pr_adj >>> F;
  assign xn     = sat(SATW'(probe_r) - SATW'(stepq));

  assign start_probe = in_slp[W-1] ? sat(SATW'(in_pos) + SATW'({1'b0, step_r}))
                                   : sat(SATW'(in_pos) - SATW'({1'b0, step_r}));

  assign dd     = (W+2)'(probe_r) - (W+2)'(kept_pos_r);
  assign dist_u = dd[W+1] ? (W+2)'(-dd) : (W+2)'(dd);
  assign far    = AW'(dist_u) > AW'(tol_r);

  cli_div #(.W(W), .F(F)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .stat  (div_stat)
  );

  cli_sqrt #(.W(W)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (disc[2*W-1:0]),
    .root  (root),
    .stat  (sq_stat)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_comb begin
    st_nxt    = st_r;
    div_start = 1'b0;
    sq_start  = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_op == OP_START) begin
            st_nxt = ST_ADV;
          end else if (phase_r == PH_FIT) begin
            st_nxt    = ST_DIV1;
            div_start = 1'b1;
          end else if (phase_r == PH_FINAL) begin
            st_nxt = ST_FIN;
          end
        end
      end
      ST_ADV, ST_FIN, ST_FAIL: if (out_free) st_nxt = ST_IDLE;
      ST_DIV1: if (div_stat.done) st_nxt = ST_D1;
      ST_D1:   st_nxt = ST_SQA;
      ST_SQA:  st_nxt = ST_SQB;
      ST_SQB:  st_nxt = ST_SQC;
      ST_SQC: begin
        if (disc[PW]) begin
          st_nxt = ST_FAIL;
        end else begin
          st_nxt   = ST_SQRT;
          sq_start = 1'b1;
        end
      end
      ST_SQRT: if (sq_stat.done) st_nxt = ST_DEN;
      ST_DEN: begin
        if (div2_den == '0) begin
          st_nxt = ST_FAIL;
        end else begin
          st_nxt    = ST_DIV2;
          div_start = 1'b1;
        end
      end
      ST_DIV2: if (div_stat.done) st_nxt = ST_STEP;
      ST_STEP: st_nxt = ST_UPD;
      ST_UPD:  st_nxt = ST_ADV;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= TOL_RST;
      step_r  <= STEP_RST;
      maxit_r <= MAXIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TOL:   tol_r   <= cfg_wdata;
        CFG_STEP:  step_r  <= cfg_wdata;
        CFG_MAXIT: maxit_r <= cfg_wdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // search state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      fit_r        <= '0;
      kept_pos_r   <= '0;
      kept_val_r   <= '0;
      kept_slp_r   <= '0;
      probe_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load)                        out_tvalid_r <= 1'b1;
      else if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (acc && in_op == OP_START) begin
            kept_pos_r <= in_pos;
            kept_val_r <= in_val;
            kept_slp_r <= in_slp;
            probe_r    <= start_probe;
            fit_r      <= '0;
          end
        end
        ST_UPD: begin
          kept_pos_r <= probe_r;
          kept_val_r <= ev_val_r;
          kept_slp_r <= ev_slp_r;
          probe_r    <= xn;
          fit_r      <= fit_r + 1'b1;
        end
        ST_ADV: begin
          if (out_free) begin
            out_iter_r <= fit_r;
            if (far && fit_r < maxit_r) begin
              phase_r    <= PH_FIT;
              out_kind_r <= KIND_EVAL;
              out_pos_r  <= probe_r;
              out_val_r  <= '0;
            end else if (fit_r >= maxit_r) begin
              phase_r    <= PH_IDLE;
              out_kind_r <= KIND_FAIL;
              out_pos_r  <= kept_pos_r;
              out_val_r  <= kept_val_r;
            end else begin
              phase_r    <= PH_FINAL;
              out_kind_r <= KIND_EVAL;
              out_pos_r  <= probe_r;
              out_val_r  <= '0;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            phase_r    <= PH_IDLE;
            out_kind_r <= KIND_CONV;
            out_iter_r <= fit_r;
            if (ev_val_r < kept_val_r) begin
              out_pos_r <= probe_r;
              out_val_r <= ev_val_r;
            end else begin
              out_pos_r <= kept_pos_r;
              out_val_r <= kept_val_r;
            end
          end
        end
        ST_FAIL: begin
          if (out_free) begin
            phase_r    <= PH_IDLE;
            out_kind_r <= KIND_FAIL;
            out_iter_r <= fit_r;
            out_pos_r  <= kept_pos_r;
            out_val_r  <= kept_val_r;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= prod;
    if (acc && in_op == OP_EVAL) begin
      ev_val_r <= in_val;
      ev_slp_r <= in_slp;
    end
    if (st_r == ST_D1)  d1_r <= sat(SATW'(kept_slp_r) + SATW'(ev_slp_r) - SATW'(quo));
    if (st_r == ST_SQB) sq_r <= prod_r;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = OUT_TDW'({out_iter_r, out_val_r, out_pos_r});

`ifndef NO_ASSERTIONS
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (st_r == ST_DIV1 || st_r == ST_DIV2))
    else $error("divider finished outside a divide step");

  a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
    sq_stat.done |-> (st_r == ST_SQRT))
    else $error("square root finished outside its step");

  a_eval_val: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_EVAL) |-> (out_val_r == '0))
    else $error("evaluation request carries a value");

  a_fit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_UPD) |=> (fit_r == ITER_W'($past(fit_r) + 1'b1)))
    else $error("fit count did not advance");
`endif

endmodule
